// ===== src/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// shared constants and types for the line minimizer
// ----------------------------------------------------------------------------
package blm_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS = 40;
	localparam int TOL_SHIFT = 26;
	localparam logic signed [63:0] ZEPS_Q = 64'sd110;
	localparam logic signed [63:0] CGOLD_Q = 64'sd419976058415;
	localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [1:0] REG_ABS_TOL = 2'd0;
	localparam logic [1:0] REG_REL_TOL = 2'd1;
	localparam logic [1:0] REG_MAX_EVALS = 2'd2;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_VALUE = 1'b1;
	localparam logic RES_EVAL = 1'b0;
	localparam logic RES_DONE = 1'b1;

	typedef struct packed {
		logic kind;
		logic signed [63:0] point_a;
		logic signed [63:0] point_x;
		logic signed [63:0] point_b;
		logic signed [63:0] value_a;
		logic signed [63:0] value_x;
		logic signed [63:0] value_b;
		logic signed [63:0] eval_value;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic signed [63:0] eval_point;
		logic signed [63:0] bracket_low;
		logic signed [63:0] bracket_best;
		logic signed [63:0] bracket_high;
		logic signed [63:0] value_low;
		logic signed [63:0] value_best;
		logic signed [63:0] value_high;
		logic [15:0] eval_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [63:0] data;
	} cfg_item_t;

	function automatic logic signed [63:0] sadd(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sneg(logic signed [63:0] v);
		return (v == S64_MIN) ? S64_MAX : -v;
	endfunction

	function automatic logic [63:0] mag(logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [63:0] from_mag(logic [63:0] m, logic neg);
		logic [63:0] s;
		s = m[63] ? S64_MAX : m;
		return neg ? -s : s;
	endfunction

	function automatic logic signed [63:0] half(logic signed [63:0] v);
		return v >>> 1;
	endfunction

endpackage

// ===== src/blm_if.sv =====
// ----------------------------------------------------------------------------
// blm_if
// valid/ready channel interfaces for items and configuration
// ----------------------------------------------------------------------------
interface blm_in_if;
	logic valid;
	logic ready;
	blm_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface blm_out_if;
	logic valid;
	logic ready;
	blm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface blm_cfg_if;
	logic valid;
	logic ready;
	blm_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/blm_mul.sv =====
// ----------------------------------------------------------------------------
// blm_mul
// shared magnitude multiplier: 64x64 over four 32x32 partial products,
// rounded to Q23.40 and saturated
// ----------------------------------------------------------------------------
module blm_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic [2:0] cnt_q;
	logic busy_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [127:0] acc_q;
	logic [31:0] pa;
	logic [31:0] pb;
	logic [63:0] pp;
	logic [127:0] sh;
	logic [127:0] rnd;

	always_comb begin
		pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = pa * pb;
		sh = {64'd0, pp} << (7'(cnt_q[1] + cnt_q[0]) * 7'd32);
		rnd = acc_q + (128'd1 << (blm_pkg::FRAC_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				a_q <= a;
				b_q <= b;
				acc_q <= '0;
			end else if (busy_q) begin
				acc_q <= acc_q + sh;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (rnd[127:103] != '0) prod = blm_pkg::S64_MAX;
		else prod = {1'b0, rnd[102:40]};
	end
endmodule

// ===== src/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// restoring divider, one quotient bit per cycle: (pm * 2^40) / qm
// ----------------------------------------------------------------------------
module blm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] pm,
	input  logic [63:0] qm,
	output logic        done,
	output logic [63:0] quo
);
	logic busy_q;
	logic [6:0] cnt_q;
	logic [127:0] num_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] qm_q;
	logic ovf_q;
	logic [64:0] rs;
	logic take;

	always_comb begin
		rs = {rem_q, num_q[127]};
		take = rs >= {1'b0, qm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				num_q <= {pm, 64'd0} >> 24;
				rem_q <= '0;
				quo_q <= '0;
				qm_q <= qm;
				ovf_q <= 1'b0;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (quo_q[63]) ovf_q <= 1'b1;
				rem_q <= take ? 64'(rs - {1'b0, qm_q}) : rs[63:0];
				quo_q <= {quo_q[62:0], take};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quo = ovf_q ? blm_pkg::S64_MAX : quo_q;
endmodule

// ===== src/brent_line_minimizer_core.sv =====
// ----------------------------------------------------------------------------
// brent_line_minimizer_core
// brent minimizer stepping on externally evaluated function values
// ----------------------------------------------------------------------------
// steps: a tolerance check on the shared multiplier ends in a finished result,
// a golden step or a parabolic step; the parabolic step uses the shared
// multiplier and then the divider, and a rejected fit falls back to golden
// throughput: one item at a time; in.ready is low until the result is taken
// reset: control and point state cleared, config registers to their defaults, block idle
module brent_line_minimizer_core (
	input  logic clk,
	input  logic arst_n,
	blm_in_if.sink   in,
	blm_out_if.source out,
	blm_cfg_if.sink  cfg
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_REL, ST_DECIDE, ST_R, ST_Q, ST_P1, ST_P2, ST_QFIX,
		ST_T1, ST_T2, ST_T3, ST_PCHK, ST_DIV, ST_PAR, ST_GOLD, ST_GOLD2,
		ST_FINAL, ST_OUT
	} state_t;

	state_t st_q;
	logic signed [63:0] a_q, b_q, x_q, w_q, v_q, fa_q, fb_q, fx_q, fw_q, fv_q;
	logic signed [63:0] d_q, e_q, u_q, oe_q, p_q, q_q, r_q, t_q;
	logic [63:0] relb_q;
	logic [blm_pkg::COUNT_BITS-1:0] evals_q;
	logic running_q;
	logic [62:0] abs_tol_q, rel_tol_q;
	logic [15:0] max_evals_q;

	logic mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, mul_p, div_p, div_q, div_o;
	logic mul_neg;
	logic wait_q;
	blm_pkg::out_item_t out_q;
	logic out_valid_q;

	blm_mul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p));
	blm_div u_div (.clk, .arst_n, .start(div_start), .pm(div_p), .qm(div_q),
		.done(div_done), .quo(div_o));

	logic signed [63:0] xm, tol1, tol2, fu, mul_s, un;
	logic [64:0] ave;
	always_comb begin
		xm = blm_pkg::sadd(blm_pkg::half(a_q), blm_pkg::half(b_q));
		tol1 = 64'(blm_pkg::mag(x_q) >> blm_pkg::TOL_SHIFT) + blm_pkg::ZEPS_Q;
		tol2 = tol1 <<< 1;
		fu = in.data.eval_value;
		ave = 65'(blm_pkg::mag(fv_q) >> 1) + 65'(blm_pkg::mag(fx_q) >> 1);
		mul_s = blm_pkg::from_mag(mul_p, mul_neg);
		un = blm_pkg::sadd(x_q, d_q);
	end

	// operand select for the shared multiplier and the divider
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_neg = 1'b0;
		unique case (st_q)
			ST_REL: begin
				mul_a = {1'b0, rel_tol_q};
				mul_b = ave[63:0];
			end
			ST_R: begin
				mul_a = blm_pkg::mag(blm_pkg::ssub(x_q, w_q));
				mul_b = blm_pkg::mag(blm_pkg::ssub(fx_q, fv_q));
				mul_neg = blm_pkg::ssub(x_q, w_q) < 0 != blm_pkg::ssub(fx_q, fv_q) < 0;
			end
			ST_Q: begin
				mul_a = blm_pkg::mag(blm_pkg::ssub(x_q, v_q));
				mul_b = blm_pkg::mag(blm_pkg::ssub(fx_q, fw_q));
				mul_neg = blm_pkg::ssub(x_q, v_q) < 0 != blm_pkg::ssub(fx_q, fw_q) < 0;
			end
			ST_P1: begin
				mul_a = blm_pkg::mag(blm_pkg::ssub(x_q, v_q));
				mul_b = blm_pkg::mag(q_q);
				mul_neg = blm_pkg::ssub(x_q, v_q) < 0 != q_q < 0;
			end
			ST_P2: begin
				mul_a = blm_pkg::mag(blm_pkg::ssub(x_q, w_q));
				mul_b = blm_pkg::mag(r_q);
				mul_neg = blm_pkg::ssub(x_q, w_q) < 0 != r_q < 0;
			end
			ST_T1: begin
				mul_a = blm_pkg::mag(q_q);
				mul_b = blm_pkg::mag(oe_q);
			end
			ST_T2: begin
				mul_a = blm_pkg::mag(q_q);
				mul_b = blm_pkg::mag(blm_pkg::ssub(a_q, x_q));
				mul_neg = blm_pkg::ssub(a_q, x_q) < 0;
			end
			ST_T3: begin
				mul_a = blm_pkg::mag(q_q);
				mul_b = blm_pkg::mag(blm_pkg::ssub(b_q, x_q));
				mul_neg = blm_pkg::ssub(b_q, x_q) < 0;
			end
			ST_GOLD2: begin
				mul_a = blm_pkg::mag(blm_pkg::CGOLD_Q);
				mul_b = blm_pkg::mag(e_q);
				mul_neg = e_q < 0;
			end
			default: ;
		endcase
		div_p = blm_pkg::mag(p_q);
		div_q = blm_pkg::mag(q_q);
	end

	assign in.ready = (st_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;
	assign out.valid = out_valid_q;
	assign out.data = out_q;

	logic signed [63:0] ps;
	always_comb begin
		ps = blm_pkg::ssub(t_q, mul_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			abs_tol_q <= 63'd1099;
			rel_tol_q <= 63'd1099512;
			max_evals_q <= 16'd100;
			{a_q, b_q, x_q, w_q, v_q, fa_q, fb_q, fx_q, fw_q, fv_q} <= '0;
			{d_q, e_q, u_q} <= '0;
			evals_q <= '0;
			running_q <= 1'b0;
			out_valid_q <= 1'b0;
			mul_start <= 1'b0;
			div_start <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			mul_start <= 1'b0;
			div_start <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg.data.index)
					blm_pkg::REG_ABS_TOL: abs_tol_q <= cfg.data.data[62:0];
					blm_pkg::REG_REL_TOL: rel_tol_q <= cfg.data.data[62:0];
					blm_pkg::REG_MAX_EVALS: max_evals_q <= cfg.data.data[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && out.ready) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in.valid && in.ready) begin
						if (in.data.kind == blm_pkg::KIND_START) begin
							a_q <= in.data.point_a;
							x_q <= in.data.point_x;
							b_q <= in.data.point_b;
							fa_q <= in.data.value_a;
							fx_q <= in.data.value_x;
							fb_q <= in.data.value_b;
							e_q <= blm_pkg::ssub(in.data.point_b, in.data.point_a);
							d_q <= '0;
							if (in.data.value_a < in.data.value_b) begin
								w_q <= in.data.point_a; fw_q <= in.data.value_a;
								v_q <= in.data.point_b; fv_q <= in.data.value_b;
							end else begin
								w_q <= in.data.point_b; fw_q <= in.data.value_b;
								v_q <= in.data.point_a; fv_q <= in.data.value_a;
							end
							evals_q <= '0;
							u_q <= '0;
							st_q <= ST_CHECK;
						end else if (running_q) begin
							if (fu <= fx_q) begin
								if (u_q >= x_q) begin a_q <= x_q; fa_q <= fx_q; end
								else begin b_q <= x_q; fb_q <= fx_q; end
								v_q <= w_q; fv_q <= fw_q;
								w_q <= x_q; fw_q <= fx_q;
								x_q <= u_q; fx_q <= fu;
							end else begin
								if (u_q < x_q) begin a_q <= u_q; fa_q <= fu; end
								else begin b_q <= u_q; fb_q <= fu; end
								if (fu <= fw_q || w_q == x_q) begin
									v_q <= w_q; fv_q <= fw_q;
									w_q <= u_q; fw_q <= fu;
								end else if (fu <= fv_q || v_q == x_q || v_q == w_q) begin
									v_q <= u_q; fv_q <= fu;
								end
							end
							if (evals_q != '1) evals_q <= evals_q + 1'b1;
							st_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					mul_start <= 1'b1;
					wait_q <= 1'b0;
					st_q <= ST_REL;
				end
				ST_REL: if (mul_done) begin
					relb_q <= mul_p;
					st_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (blm_pkg::ssub(fv_q, fx_q) <= $signed({1'b0, abs_tol_q}) ||
							blm_pkg::ssub(fv_q, fx_q) <= $signed(relb_q) ||
							32'(evals_q) >= 32'(max_evals_q)) begin
						running_q <= 1'b0;
						out_q <= '{blm_pkg::RES_DONE, 64'sd0, a_q, x_q, b_q, fa_q, fx_q, fb_q,
							16'(evals_q)};
						st_q <= ST_OUT;
					end else if (blm_pkg::mag(e_q) > tol1) begin
						mul_start <= 1'b1;
						st_q <= ST_R;
					end else st_q <= ST_GOLD;
				end
				ST_R: if (mul_done) begin
					r_q <= mul_s; mul_start <= 1'b1; st_q <= ST_Q;
				end
				ST_Q: if (mul_done) begin
					q_q <= mul_s; mul_start <= 1'b1; st_q <= ST_P1;
				end
				ST_P1: if (mul_done) begin
					t_q <= mul_s; mul_start <= 1'b1; st_q <= ST_P2;
				end
				ST_P2: if (mul_done) begin
					p_q <= ps;
					q_q <= blm_pkg::ssub(q_q, r_q);
					st_q <= ST_QFIX;
				end
				ST_QFIX: begin
					if (blm_pkg::sadd(q_q, q_q) > 0) p_q <= blm_pkg::sneg(p_q);
					q_q <= blm_pkg::from_mag(blm_pkg::mag(blm_pkg::sadd(q_q, q_q)), 1'b0);
					oe_q <= e_q;
					e_q <= d_q;
					mul_start <= 1'b1;
					st_q <= ST_T1;
				end
				ST_T1: if (mul_done) begin
					if (blm_pkg::mag(p_q) >= (mul_p >> 1)) st_q <= ST_GOLD;
					else begin mul_start <= 1'b1; st_q <= ST_T2; end
				end
				ST_T2: if (mul_done) begin
					if (p_q <= mul_s) st_q <= ST_GOLD;
					else begin mul_start <= 1'b1; st_q <= ST_T3; end
				end
				ST_T3: if (mul_done) begin
					if (p_q >= mul_s) st_q <= ST_GOLD;
					else begin div_start <= 1'b1; st_q <= ST_DIV; end
				end
				ST_DIV: if (div_done) begin
					d_q <= blm_pkg::from_mag(div_o, p_q[63]);
					st_q <= ST_PAR;
				end
				ST_PAR: begin
					if (blm_pkg::ssub(un, a_q) < tol2 || blm_pkg::ssub(b_q, un) < tol2)
						d_q <= (blm_pkg::ssub(xm, x_q) > 0) ? tol1 : -tol1;
					st_q <= ST_FINAL;
				end
				ST_GOLD: begin
					e_q <= (x_q >= xm) ? blm_pkg::ssub(a_q, x_q) : blm_pkg::ssub(b_q, x_q);
					st_q <= ST_PCHK;
				end
				ST_PCHK: begin
					mul_start <= 1'b1;
					st_q <= ST_GOLD2;
				end
				ST_GOLD2: if (mul_done) begin
					d_q <= mul_s;
					st_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (blm_pkg::mag(d_q) >= tol1) u_q <= un;
					else u_q <= blm_pkg::sadd(x_q, (d_q > 0) ? tol1 : -tol1);
					running_q <= 1'b1;
					st_q <= ST_OUT;
					wait_q <= 1'b1;
				end
				ST_OUT: begin
					if (wait_q)
						out_q <= '{blm_pkg::RES_EVAL, u_q, a_q, x_q, b_q, fa_q, fx_q, fb_q,
							16'(evals_q)};
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
